[rtl/ccps_pkg.sv]
// Package for the character class pattern search block.
// Holds the field widths, codes, element type, outcome type and cell status type.
// Used by ccps_cell and char_class_pattern_search; depends on nothing.
package ccps_pkg;

    localparam int CHAR_W    = 8;
    localparam int POS_W     = 16;
    localparam int LEN_W     = 5;
    localparam int IDX_W     = 4;
    localparam int KIND_W    = 3;
    localparam int COUNT_W   = 3;
    localparam int SET_SLOTS = 4;
    localparam int SET_W     = SET_SLOTS * CHAR_W;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 24;

    localparam logic [KIND_W-1:0] KIND_LITERAL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ANY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UPPER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NSET    = 3'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    localparam logic [CHAR_W-1:0] CH_LOWER_FIRST = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_LAST  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_LAST  = 8'h5A;

    typedef enum logic [STATUS_W-1:0] {
        OUT_SEARCH = 2'd0,
        OUT_FOUND  = 2'd1,
        OUT_NONE   = 2'd2,
        OUT_ERROR  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [SET_W-1:0]   chars;
    } elem_t;

    typedef struct packed {
        logic err;
        logic tail_hit;
    } cell_status_t;

endpackage

[rtl/ccps_cell.sv]
// One pattern position of the shift-and chain: element storage and prefix bit.
// Takes the prefix bit of its left neighbor and hands its own to the right.
// Depends on ccps_pkg.
module ccps_cell
    import ccps_pkg::*;
#(
    parameter int CLASS_CHARS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_en,
    input  elem_t              load_elem,
    input  logic               step_en,
    input  logic               clear_en,
    input  logic               cell_en,
    input  logic               tail,
    input  logic               prefix_in,
    input  logic [CHAR_W-1:0]  text_char,
    output logic               active,
    output cell_status_t       status
);

    localparam int SET_LIM = (CLASS_CHARS < SET_SLOTS) ? CLASS_CHARS : SET_SLOTS;

    elem_t              elem_reg;
    logic               active_reg;
    logic               active_next;
    logic               cand;
    logic               hit;
    logic               in_set;
    logic               malformed;
    logic [COUNT_W-1:0] count_sat;

    always_ff @(posedge aclk) begin
        if (load_en) begin
            elem_reg <= load_elem;
        end
    end

    always_comb begin
        count_sat = (elem_reg.count > COUNT_W'(SET_LIM)) ? COUNT_W'(SET_LIM) : elem_reg.count;
        in_set = 1'b0;
        for (int k = 0; k < SET_SLOTS; k++) begin
            if ((COUNT_W'(k) < count_sat)
                    && (elem_reg.chars[k*CHAR_W +: CHAR_W] == text_char)) begin
                in_set = 1'b1;
            end
        end
        case (elem_reg.kind)
            KIND_LITERAL: hit = (elem_reg.chars[CHAR_W-1:0] == text_char);
            KIND_ANY:     hit = 1'b1;
            KIND_LOWER:   hit = (text_char >= CH_LOWER_FIRST) && (text_char <= CH_LOWER_LAST);
            KIND_UPPER:   hit = (text_char >= CH_UPPER_FIRST) && (text_char <= CH_UPPER_LAST);
            KIND_SET:     hit = in_set;
            KIND_NSET:    hit = !in_set;
            default:      hit = 1'b0;
        endcase
        malformed       = (elem_reg.kind > KIND_NSET);
        cand            = prefix_in && cell_en;
        active_next     = cand && hit && !malformed;
        status.err      = cand && malformed;
        status.tail_hit = active_next && tail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_en) begin
            active_reg <= 1'b0;
        end else if (step_en) begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

[rtl/char_class_pattern_search.sv]
// Top level of the character class pattern search block.
// Instantiates one ccps_cell per pattern position and holds the search state.
// Depends on ccps_pkg and ccps_cell.
//
// The block takes one item per clock cycle on the s_ stream: a pattern element load
// (tuser low) or one text character (tuser high, tlast on the final character).
// Every pattern position is a cell that compares the character in parallel, and
// the prefix bits shift one cell to the right per character, so one text character
// is processed each cycle with its result registered on the m_ stream in the cycle
// after; the output register is the only thing that can hold the input back, and it
// does so only while a result waits and m_tready is low. Each text transfer yields
// one result: searching, found with the start index, not found on the last character,
// or pattern error. The user must write the pattern length register on the cfg
// channel only while the block is idle (not enforced); loaded elements have no reset value.
module char_class_pattern_search
    import ccps_pkg::*;
#(
    parameter int PATTERN_DEPTH = 16,
    parameter int CLASS_CHARS   = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // elem_index, elem_kind, set_count, set_char_a, set_char_b, set_char_c,
    // set_char_d, text_char, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, match_position, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data
);

    localparam int LEN_MAX   = (1 << LEN_W) - 1;
    localparam int DEPTH_CAP = (PATTERN_DEPTH < LEN_MAX) ? PATTERN_DEPTH : LEN_MAX;

    logic [IDX_W-1:0]         elem_index;
    logic [CHAR_W-1:0]        text_char;
    elem_t                    load_elem;
    logic                     s_fire;
    logic                     load_fire;
    logic                     text_fire;
    logic                     step_en;

    logic [LEN_W-1:0]         pattern_length_reg;
    logic [LEN_W-1:0]         len_eff;
    logic [POS_W-1:0]         char_position_reg;
    logic [POS_W-1:0]         char_position_next;
    outcome_t                 outcome_reg;
    outcome_t                 outcome_next;
    outcome_t                 status_out;
    logic [POS_W-1:0]         found_start_reg;
    logic [POS_W-1:0]         found_start_next;
    logic [POS_W-1:0]         pos_out;

    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;

    logic [PATTERN_DEPTH-1:0] active_vec;
    logic [PATTERN_DEPTH-1:0] err_vec;
    logic [PATTERN_DEPTH-1:0] tail_vec;
    logic                     found_now;
    logic                     err_now;

    assign elem_index      = s_tdata[3:0];
    assign load_elem.kind  = s_tdata[6:4];
    assign load_elem.count = s_tdata[9:7];
    assign load_elem.chars = s_tdata[41:10];
    assign text_char       = s_tdata[49:42];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign load_fire = s_fire && (s_tuser == REQ_LOAD);
    assign text_fire = s_fire && (s_tuser == REQ_TEXT);
    assign step_en   = text_fire && (outcome_reg == OUT_SEARCH);
    assign cfg_ready = 1'b1;

    assign len_eff = (pattern_length_reg > LEN_W'(DEPTH_CAP)) ? LEN_W'(DEPTH_CAP)
                                                              : pattern_length_reg;

    for (genvar j = 0; j < PATTERN_DEPTH; j++) begin : g_cell
        logic         prefix_in;
        cell_status_t cell_status;

        if (j == 0) begin : g_head
            assign prefix_in = 1'b1;
        end else begin : g_link
            assign prefix_in = active_vec[j-1];
        end

        ccps_cell #(
            .CLASS_CHARS(CLASS_CHARS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (load_fire && (int'(elem_index) == j)),
            .load_elem (load_elem),
            .step_en   (step_en),
            .clear_en  (text_fire && s_tlast),
            .cell_en   (int'(len_eff) > j),
            .tail      (int'(len_eff) == j + 1),
            .prefix_in (prefix_in),
            .text_char (text_char),
            .active    (active_vec[j]),
            .status    (cell_status)
        );

        assign err_vec[j]  = cell_status.err;
        assign tail_vec[j] = cell_status.tail_hit;
    end

    assign found_now = (len_eff == '0) || (|tail_vec);
    assign err_now   = |err_vec;

    always_comb begin
        outcome_next       = outcome_reg;
        found_start_next   = found_start_reg;
        char_position_next = char_position_reg;
        if (outcome_reg == OUT_SEARCH) begin
            char_position_next = char_position_reg + POS_W'(1);
            if (err_now) begin
                outcome_next = OUT_ERROR;
            end else if (found_now) begin
                outcome_next = OUT_FOUND;
                if (len_eff == '0) begin
                    found_start_next = char_position_reg;
                end else begin
                    found_start_next = char_position_reg - POS_W'(len_eff) + POS_W'(1);
                end
            end
        end
        status_out = outcome_next;
        if ((outcome_next == OUT_SEARCH) && s_tlast) begin
            status_out = OUT_NONE;
        end
        pos_out = (status_out == OUT_FOUND) ? found_start_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            pattern_length_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outcome_reg       <= OUT_SEARCH;
            char_position_reg <= '0;
            found_start_reg   <= '0;
        end else if (text_fire) begin
            if (s_tlast) begin
                outcome_reg       <= OUT_SEARCH;
                char_position_reg <= '0;
                found_start_reg   <= '0;
            end else begin
                outcome_reg       <= outcome_next;
                char_position_reg <= char_position_next;
                found_start_reg   <= found_start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (text_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (text_fire) begin
            m_tdata_reg <= {{(M_DATA_W - STATUS_W - POS_W){1'b0}}, pos_out, status_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        text_fire && s_tlast |=> (outcome_reg == OUT_SEARCH) && (char_position_reg == '0)
            && (active_vec == '0))
        else $error("Search state not cleared after the last character.");

    a_decided_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (outcome_reg != OUT_SEARCH) && !(text_fire && s_tlast)
            |=> $stable(outcome_reg) && $stable(found_start_reg) && $stable(char_position_reg))
        else $error("A decided outcome changed before the end of the text.");

    a_position_only_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STATUS_W-1:0] != OUT_FOUND)
            |-> (m_tdata[STATUS_W +: POS_W] == '0))
        else $error("Match position is nonzero on a result that is not found.");

    a_error_wins: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && err_now && !s_tlast |=> (outcome_reg == OUT_ERROR))
        else $error("A reached malformed element did not end in a pattern error.");
`endif

endmodule
